/* hw/rtl/hds_pkg.sv */
`timescale 1ns / 1ps
package hds_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam int TEMP_MAX       = 16777215;
  localparam int STENCIL_CENTER = 6;

  // stencil taps in the order they are read
  localparam logic [2:0] TAP_C  = 3'd0;
  localparam logic [2:0] TAP_XM = 3'd1;
  localparam logic [2:0] TAP_XP = 3'd2;
  localparam logic [2:0] TAP_YM = 3'd3;
  localparam logic [2:0] TAP_YP = 3'd4;
  localparam logic [2:0] TAP_ZM = 3'd5;
  localparam logic [2:0] TAP_ZP = 3'd6;

  typedef struct packed {
    logic       cfg_we;
    logic       cfg_e2;
    logic       cfg_tot;
    logic       load_wr;
    logic       host_rd;
    logic       sw_start;
    logic       sw_rd;
    logic [2:0] tap;
    logic       sw_mul;
    logic       sw_wr;
    logic       cp_rd;
    logic       out_load;
  } hds_cmd_t;

  typedef struct packed {
    logic wall;
    logic last_node;
  } hds_sts_t;

endpackage

/* hw/rtl/hds_ram.sv */
`timescale 1ns / 1ps
module hds_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/hds_ctrl.sv */
`timescale 1ns / 1ps
module hds_ctrl
  import hds_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic [1:0] s_op,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  hds_sts_t sts,
  output hds_cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE, CFG1, CFG2, RDOUT, SW_RD, SW_WAIT, SW_MUL, SW_WR, SW_CP, SW_CPW
  } state_t;

  state_t     state;
  logic [2:0] tap;
  logic       in_acc;
  logic       out_free;

  // a config write wins over a word offered in the same cycle
  assign s_tready = (state == IDLE) && !cfg_valid;
  assign cfg_ready = (state == IDLE);
  assign in_acc = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd = '0;
    cmd.cfg_we   = cfg_valid && cfg_ready;
    cmd.cfg_e2   = (state == CFG1);
    cmd.cfg_tot  = (state == CFG2);
    cmd.load_wr  = in_acc && (s_op == OP_LOAD);
    cmd.host_rd  = in_acc && (s_op == OP_READ);
    cmd.sw_start = in_acc && (s_op == OP_STEP);
    cmd.sw_rd    = (state == SW_RD);
    cmd.tap      = tap;
    cmd.sw_mul   = (state == SW_MUL);
    cmd.sw_wr    = (state == SW_WR);
    cmd.cp_rd    = (state == SW_CP);
    cmd.out_load = (state == RDOUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      tap      <= TAP_C;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == RDOUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          tap <= TAP_C;
          if (cfg_valid) begin
            state <= CFG1;
          end else if (in_acc) begin
            case (s_op)
              OP_READ: state <= RDOUT;
              OP_STEP: state <= SW_RD;
              default: state <= IDLE;
            endcase
          end
        end
        CFG1: state <= CFG2;
        CFG2: state <= IDLE;
        RDOUT: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        SW_RD: begin
          // wall nodes only need their own old value
          if (sts.wall || tap == TAP_ZP) begin
            tap   <= TAP_C;
            state <= SW_WAIT;
          end else begin
            tap <= tap + 3'd1;
          end
        end
        SW_WAIT: state <= SW_MUL;
        SW_MUL:  state <= SW_WR;
        SW_WR:   state <= sts.last_node ? SW_CP : SW_RD;
        SW_CP: begin
          if (sts.last_node) begin
            state <= SW_CPW;
          end
        end
        SW_CPW:  state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/hds_dp.sv */
`timescale 1ns / 1ps
module hds_dp
  import hds_pkg::*;
#(
  parameter int EDGE_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  hds_cmd_t    cmd,
  output hds_sts_t    sts,
  input  logic [87:0] s_tdata,
  input  logic [5:0]  cfg_data,
  output logic [39:0] m_tdata
);

  localparam int DEPTH = EDGE_MAX * EDGE_MAX * EDGE_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int EW    = $clog2(EDGE_MAX + 1);
  localparam int E2W   = $clog2(EDGE_MAX * EDGE_MAX + 1);
  localparam int CW    = (TW > 15) ? TW : 15;
  localparam int RST_E = (EDGE_MAX < 32) ? EDGE_MAX : 32;
  localparam logic [6:0] EMAX7 = 7'(EDGE_MAX);

  logic [14:0] in_idx;
  logic [23:0] in_temp;
  logic [19:0] in_gain;
  logic [23:0] in_rise;
  assign in_idx  = s_tdata[14:0];
  assign in_temp = s_tdata[38:15];
  assign in_gain = s_tdata[58:39];
  assign in_rise = s_tdata[82:59];

  logic [EW-1:0]  e;
  logic [E2W-1:0] e2;
  logic [TW-1:0]  total;
  logic [6:0]     raw7;
  logic [EW-1:0]  e_cl;
  logic           in_range;

  assign raw7 = {1'b0, cfg_data};
  always_comb begin
    if (raw7 < 7'd3) begin
      e_cl = EW'(3);
    end else if (raw7 > EMAX7) begin
      e_cl = EW'(EDGE_MAX);
    end else begin
      e_cl = EW'(raw7);
    end
  end

  assign in_range = CW'(in_idx) < CW'(total);

  always_ff @(posedge clk) begin
    if (rst) begin
      e     <= EW'(RST_E);
      e2    <= E2W'(RST_E * RST_E);
      total <= TW'(RST_E * RST_E * RST_E);
    end else begin
      if (cmd.cfg_we) begin
        e <= e_cl;
      end
      if (cmd.cfg_e2) begin
        e2 <= E2W'(e) * E2W'(e);
      end
      if (cmd.cfg_tot) begin
        total <= TW'(e2) * TW'(e);
      end
    end
  end

  // sweep position
  logic [AW-1:0] n;
  logic [EW-1:0] x, y, z;
  logic [AW-1:0] src;
  logic [AW-1:0] tap_addr;
  logic [AW-1:0] e_a, e2_a;

  assign e_a  = AW'(e);
  assign e2_a = AW'(e2);
  assign sts.wall = (x == '0) || (x == e - EW'(1)) || (y == '0) || (y == e - EW'(1));
  assign sts.last_node = TW'(n) == total - TW'(1);

  // bottom and top faces take the new value of the layer next to them
  always_comb begin
    if (z == '0) begin
      src = n + e2_a;
    end else if (z == e - EW'(1)) begin
      src = n - e2_a;
    end else begin
      src = n;
    end
  end

  always_comb begin
    case (cmd.tap)
      TAP_XM:  tap_addr = src - AW'(1);
      TAP_XP:  tap_addr = src + AW'(1);
      TAP_YM:  tap_addr = src - e_a;
      TAP_YP:  tap_addr = src + e_a;
      TAP_ZM:  tap_addr = src - e2_a;
      TAP_ZP:  tap_addr = src + e2_a;
      default: tap_addr = src;
    endcase
  end

  // memories: u_temp0 holds the current values, u_temp1 the values of a sweep
  logic          load_ok;
  logic [AW-1:0] t_raddr, t_waddr;
  logic [23:0]   t_wdata, rd0, rd1, t_old;
  logic          t_re, we0, we1;
  logic [19:0]   gain_q;
  logic [23:0]   rise_q;
  logic          gr_re;
  logic [23:0]   result;
  logic          cp_d;
  logic [AW-1:0] cp_addr;

  assign load_ok = cmd.load_wr && in_range;
  assign t_re    = cmd.host_rd || cmd.sw_rd;
  assign t_raddr = cmd.host_rd ? AW'(in_idx) : tap_addr;
  assign t_waddr = load_ok ? AW'(in_idx) : cp_addr;
  assign t_wdata = load_ok ? in_temp : rd1;
  assign we0 = load_ok || cp_d;
  assign we1 = cmd.sw_wr;
  assign t_old = rd0;
  assign gr_re = cmd.sw_rd && (cmd.tap == TAP_C);

  hds_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_temp0 (
    .clk, .we(we0), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(rd0)
  );
  hds_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_temp1 (
    .clk, .we(we1), .waddr(n), .wdata(result),
    .re(cmd.cp_rd), .raddr(n), .rdata(rd1)
  );
  hds_ram #(.WIDTH(20), .DEPTH(DEPTH)) u_gain (
    .clk, .we(load_ok), .waddr(AW'(in_idx)), .wdata(in_gain),
    .re(gr_re), .raddr(src), .rdata(gain_q)
  );
  hds_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_rise (
    .clk, .we(load_ok), .waddr(AW'(in_idx)), .wdata(in_rise),
    .re(gr_re), .raddr(src), .rdata(rise_q)
  );

  // stencil arithmetic
  logic               rd_d;
  logic [2:0]         tap_d;
  logic [23:0]        center;
  logic signed [27:0] acc;
  logic signed [47:0] prod;
  logic [26:0]        c_x6;
  logic signed [48:0] q;
  logic signed [28:0] delta;
  logic signed [30:0] v;
  logic [20:0]        rise_r;

  assign c_x6   = 27'(t_old) * 27'(STENCIL_CENTER);
  assign q      = 49'(prod) + 49'sd524288;
  assign delta  = 29'(q >>> 20);
  assign rise_r = 21'((25'(rise_q) + 25'd8) >> 4);
  assign v = 31'($signed({1'b0, center})) + 31'(delta) + 31'($signed({1'b0, rise_r}));

  always_comb begin
    if (sts.wall) begin
      result = center;
    end else if (v < 0) begin
      result = '0;
    end else if (v > 31'(TEMP_MAX)) begin
      result = 24'(TEMP_MAX);
    end else begin
      result = v[23:0];
    end
  end

  always_ff @(posedge clk) begin
    tap_d   <= cmd.tap;
    cp_addr <= n;
    if (rd_d) begin
      if (tap_d == TAP_C) begin
        center <= t_old;
        acc    <= -$signed({1'b0, c_x6});
      end else begin
        acc <= acc + $signed({4'b0, t_old});
      end
    end
    if (cmd.sw_mul) begin
      prod <= acc * $signed({1'b0, gain_q});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_d <= 1'b0;
      cp_d <= 1'b0;
      n    <= '0;
      x    <= '0;
      y    <= '0;
      z    <= '0;
    end else begin
      rd_d <= cmd.sw_rd;
      cp_d <= cmd.cp_rd;
      if (cmd.sw_start) begin
        n <= '0;
        x <= '0;
        y <= '0;
        z <= '0;
      end else if (cmd.sw_wr) begin
        // after the last node the counter restarts for the copy pass
        n <= sts.last_node ? '0 : n + AW'(1);
        if (x == e - EW'(1)) begin
          x <= '0;
          if (y == e - EW'(1)) begin
            y <= '0;
            z <= z + EW'(1);
          end else begin
            y <= y + EW'(1);
          end
        end else begin
          x <= x + EW'(1);
        end
      end else if (cmd.cp_rd) begin
        n <= n + AW'(1);
      end
    end
  end

  // read result
  logic [14:0] rd_idx;
  logic        rd_oor;
  logic [14:0] out_idx;
  logic [23:0] out_temp;
  logic        out_st;

  always_ff @(posedge clk) begin
    if (cmd.host_rd) begin
      rd_idx <= in_idx;
      rd_oor <= !in_range;
    end
    if (cmd.out_load) begin
      out_idx  <= rd_idx;
      out_temp <= rd_oor ? 24'd0 : t_old;
      out_st   <= rd_oor;
    end
  end

  assign m_tdata = {out_st, out_temp, out_idx};

endmodule

/* hw/rtl/heat_diffusion_stencil_3d.sv */
`timescale 1ns / 1ps
// channel   signals                              word
// s_        s_tvalid s_tready s_tdata s_tuser    load, step or read command
// m_        m_tvalid m_tready m_tdata            read result
// cfg_      cfg_valid cfg_ready cfg_data         edge_nodes
//
// load and op 3 are taken without leaving the idle state; a read passes through
// RDOUT before its result stands in the output register, and waits in RDOUT while
// that register is still waiting to be taken; a step reads the seven stencil taps
// of an interior node, or the centre only of a wall node, then multiplies and
// writes, and then copies the new values back into the current buffer node by node
// a config write runs CFG1 then CFG2 while edge squared and edge cubed are worked out
// reset is synchronous and needs no clearing pass; stores hold garbage until loaded
module heat_diffusion_stencil_3d
  import hds_pkg::*;
#(
  parameter int EDGE_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // node_index, temperature, diffusion_gain, heat_rise
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // node_index_res, temperature_res, status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  hds_cmd_t cmd;
  hds_sts_t sts;

  hds_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .s_op(s_tuser), .cfg_valid, .cfg_ready,
    .m_tvalid, .m_tready, .sts, .cmd
  );

  hds_dp #(.EDGE_MAX(EDGE_MAX)) u_dp (
    .clk, .rst, .cmd, .sts, .s_tdata, .cfg_data, .m_tdata
  );

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[39] |-> m_tdata[38:15] == 24'd0)
    else $error("out of range read with nonzero temperature");

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_tready && !cfg_ready)
    else $error("item taken during config update");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !cfg_valid && s_tuser == OP_STEP |=> !s_tready)
    else $error("item taken during sweep");

endmodule
